FILE: rtl/js_comment_whitespace_skipper_macros.svh
// Assertion macros shared by the comment and whitespace skipper RTL.
`ifndef JS_COMMENT_WHITESPACE_SKIPPER_MACROS_SVH
`define JS_COMMENT_WHITESPACE_SKIPPER_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define JCWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define JCWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JCWS_ASSERT(lbl, prop, msg)
`define JCWS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/jcws_pkg.sv
// Types, constants and character tests for the comment and whitespace skipper.
`timescale 1ns / 1ps
`default_nettype none
package jcws_pkg;

  localparam int unsigned LOOKAHEAD_DEPTH = 3;
  localparam int unsigned BUF_DEPTH       = LOOKAHEAD_DEPTH + 1;
  localparam int unsigned CNT_W           = 3;
  localparam int unsigned POS_W           = 24;
  localparam logic [POS_W-1:0] POS_MAX    = '1;

  localparam logic [15:0] CH_LF      = 16'h000A;
  localparam logic [15:0] CH_CR      = 16'h000D;
  localparam logic [15:0] CH_BANG    = 16'h0021;
  localparam logic [15:0] CH_STAR    = 16'h002A;
  localparam logic [15:0] CH_DASH    = 16'h002D;
  localparam logic [15:0] CH_SLASH   = 16'h002F;
  localparam logic [15:0] CH_LESS    = 16'h003C;
  localparam logic [15:0] CH_GREATER = 16'h003E;

  typedef enum logic [2:0] {
    CLS_CODE      = 3'd0,
    CLS_WS        = 3'd1,
    CLS_LINE_TERM = 3'd2,
    CLS_DELIM     = 3'd3,
    CLS_BODY      = 3'd4,
    CLS_TOKEN     = 3'd5
  } unit_class_e;

  typedef enum logic [2:0] {
    KIND_NONE       = 3'd0,
    KIND_LINE       = 3'd1,
    KIND_BLOCK      = 3'd2,
    KIND_HTML_OPEN  = 3'd3,
    KIND_HTML_CLOSE = 3'd4
  } comment_kind_e;

  typedef enum logic [2:0] {
    SCAN_NORMAL     = 3'd0,
    SCAN_LINE       = 3'd1,
    SCAN_BLOCK      = 3'd2,
    SCAN_HTML_OPEN  = 3'd3,
    SCAN_HTML_CLOSE = 3'd4,
    SCAN_BLOCK_LT   = 3'd5
  } scan_mode_e;

  // all results of one input word, in source order
  typedef struct packed {
    logic [BUF_DEPTH-1:0][15:0]    units;
    unit_class_e [BUF_DEPTH-1:0]   classes;
    comment_kind_e [BUF_DEPTH-1:0] kinds;
    logic [CNT_W-1:0]              count;
    logic                          unterm;
    logic                          eos;
  } batch_t;

  // result word currently presented
  typedef struct packed {
    logic [15:0]   unit;
    unit_class_e   cls;
    comment_kind_e kind;
    logic          last;
    logic          unterm;
    logic          eos;
  } word_t;

  function automatic logic is_lt(input logic [15:0] u);
    return (u == CH_LF) || (u == CH_CR) || (u == 16'h2028) || (u == 16'h2029);
  endfunction

  function automatic logic is_ws(input logic [15:0] u);
    return (u == 16'h0009) || (u == 16'h000B) || (u == 16'h000C) ||
           (u == 16'h0020) || (u == 16'h00A0) || (u == 16'hFEFF) ||
           (u == 16'h1680) || (u == 16'h202F) || (u == 16'h205F) ||
           (u == 16'h3000) || ((u >= 16'h2000) && (u <= 16'h200A));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/jcws_classifier.sv
// Trivia scanner: lookahead hold, scan mode and per-unit classification.
`timescale 1ns / 1ps
`default_nettype none
`include "js_comment_whitespace_skipper_macros.svh"
module jcws_classifier (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_wr_en_i,
  input  wire logic            cfg_wr_data_i,
  input  wire logic            in_fire_i,
  input  wire logic [15:0]     code_unit_i,
  input  wire logic            in_token_i,
  input  wire logic            end_of_source_i,
  output jcws_pkg::batch_t     batch_o
);

  localparam int unsigned BD = jcws_pkg::BUF_DEPTH;
  localparam int unsigned LD = jcws_pkg::LOOKAHEAD_DEPTH;

  typedef enum logic [1:0] {
    PROBE_MISS = 2'd0,
    PROBE_HIT  = 2'd1,
    PROBE_WAIT = 2'd2
  } probe_e;

  logic                   module_mode_q;
  jcws_pkg::scan_mode_e   scan_q;
  logic                   ats_q;
  logic [1:0]             held_count_q;
  logic [LD-1:0][15:0]    held_q;
  logic [LD-1:0][15:0]    held_d;

  logic [BD-1:0][15:0]          ubuf;
  logic [2:0]                   n_w;
  jcws_pkg::scan_mode_e         mode_w;
  logic                         ats_w;
  logic [2:0]                   pos_w;
  jcws_pkg::unit_class_e [BD-1:0]   cls_w;
  jcws_pkg::comment_kind_e [BD-1:0] kind_w;

  // '-->' tail: '-' '>'
  function automatic probe_e probe_close(input logic [2:0] rem, input logic [15:0] n1,
                                         input logic [15:0] n2);
    if (rem < 3'd2) return PROBE_WAIT;
    if (n1 != jcws_pkg::CH_DASH) return PROBE_MISS;
    if (rem < 3'd3) return PROBE_WAIT;
    if (n2 != jcws_pkg::CH_GREATER) return PROBE_MISS;
    return PROBE_HIT;
  endfunction

  // '<!--' tail: '!' '-' '-'
  function automatic probe_e probe_open(input logic [2:0] rem, input logic [15:0] n1,
                                        input logic [15:0] n2, input logic [15:0] n3);
    if (rem < 3'd2) return PROBE_WAIT;
    if (n1 != jcws_pkg::CH_BANG) return PROBE_MISS;
    if (rem < 3'd3) return PROBE_WAIT;
    if (n2 != jcws_pkg::CH_DASH) return PROBE_MISS;
    if (rem < 3'd4) return PROBE_WAIT;
    if (n3 != jcws_pkg::CH_DASH) return PROBE_MISS;
    return PROBE_HIT;
  endfunction

  always_comb begin : build_buf
    for (int i = 0; i < LD; i++) begin
      ubuf[i] = held_q[i];
    end
    ubuf[BD-1] = '0;
    if (!in_token_i) begin
      ubuf[held_count_q] = code_unit_i;
    end
    n_w = {1'b0, held_count_q} + {2'b00, !in_token_i};
  end

  always_comb begin : scan_walk
    jcws_pkg::scan_mode_e    mode;
    logic                    ats;
    logic                    hold;
    logic                    can_wait;
    logic [2:0]              pos;
    logic [2:0]              rem;
    logic [2:0]              cnt;
    logic [15:0]             u;
    logic [15:0]             n1;
    logic [15:0]             n2;
    logic [15:0]             n3;
    jcws_pkg::unit_class_e   cls;
    jcws_pkg::comment_kind_e kind;
    probe_e                  pc;
    probe_e                  po;
    mode     = scan_q;
    ats      = ats_q;
    hold     = 1'b0;
    can_wait = !end_of_source_i && !in_token_i;
    pos      = '0;
    rem      = '0;
    cnt      = '0;
    u        = '0;
    n1       = '0;
    n2       = '0;
    n3       = '0;
    cls      = jcws_pkg::CLS_CODE;
    kind     = jcws_pkg::KIND_NONE;
    pc       = PROBE_MISS;
    po       = PROBE_MISS;
    for (int j = 0; j < BD; j++) begin
      cls_w[j]  = jcws_pkg::CLS_CODE;
      kind_w[j] = jcws_pkg::KIND_NONE;
    end
    for (int s = 0; s < BD; s++) begin
      cnt  = '0;
      cls  = jcws_pkg::CLS_CODE;
      kind = jcws_pkg::KIND_NONE;
      if ((pos < n_w) && !hold) begin
        u   = ubuf[pos[1:0]];
        n1  = ubuf[pos[1:0] + 2'd1];
        n2  = ubuf[pos[1:0] + 2'd2];
        n3  = ubuf[pos[1:0] + 2'd3];
        rem = n_w - pos;
        pc  = probe_close(rem, n1, n2);
        po  = probe_open(rem, n1, n2, n3);
        unique case (mode)
          jcws_pkg::SCAN_NORMAL: begin
            priority if (jcws_pkg::is_ws(u)) begin
              cnt = 3'd1;
              cls = jcws_pkg::CLS_WS;
            end else if (jcws_pkg::is_lt(u)) begin
              cnt = 3'd1;
              cls = jcws_pkg::CLS_LINE_TERM;
              ats = 1'b1;
            end else if ((u == jcws_pkg::CH_SLASH) && (rem < 3'd2) && can_wait) begin
              hold = 1'b1;
            end else if ((u == jcws_pkg::CH_SLASH) && (rem >= 3'd2) &&
                         ((n1 == jcws_pkg::CH_SLASH) || (n1 == jcws_pkg::CH_STAR))) begin
              cnt = 3'd2;
              cls = jcws_pkg::CLS_DELIM;
              if (n1 == jcws_pkg::CH_SLASH) begin
                kind = jcws_pkg::KIND_LINE;
                mode = jcws_pkg::SCAN_LINE;
              end else begin
                kind = jcws_pkg::KIND_BLOCK;
                mode = jcws_pkg::SCAN_BLOCK;
              end
            end else if ((u == jcws_pkg::CH_DASH) && ats && (pc != PROBE_MISS) &&
                         ((pc == PROBE_HIT) || can_wait)) begin
              if (pc == PROBE_WAIT) begin
                hold = 1'b1;
              end else begin
                cnt  = 3'd3;
                cls  = jcws_pkg::CLS_DELIM;
                kind = jcws_pkg::KIND_HTML_CLOSE;
                mode = jcws_pkg::SCAN_HTML_CLOSE;
              end
            end else if ((u == jcws_pkg::CH_LESS) && !module_mode_q && (po != PROBE_MISS) &&
                         ((po == PROBE_HIT) || can_wait)) begin
              if (po == PROBE_WAIT) begin
                hold = 1'b1;
              end else begin
                cnt  = 3'd4;
                cls  = jcws_pkg::CLS_DELIM;
                kind = jcws_pkg::KIND_HTML_OPEN;
                mode = jcws_pkg::SCAN_HTML_OPEN;
              end
            end else begin
              cnt = 3'd1;
              cls = jcws_pkg::CLS_CODE;
              ats = 1'b0;
            end
          end
          jcws_pkg::SCAN_BLOCK, jcws_pkg::SCAN_BLOCK_LT: begin
            kind = jcws_pkg::KIND_BLOCK;
            priority if (jcws_pkg::is_lt(u)) begin
              cnt  = 3'd1;
              cls  = jcws_pkg::CLS_LINE_TERM;
              mode = jcws_pkg::SCAN_BLOCK_LT;
            end else if ((u == jcws_pkg::CH_STAR) && (rem < 3'd2) && can_wait) begin
              hold = 1'b1;
            end else if ((u == jcws_pkg::CH_STAR) && (rem >= 3'd2) &&
                         (n1 == jcws_pkg::CH_SLASH)) begin
              cnt = 3'd2;
              cls = jcws_pkg::CLS_DELIM;
              if (mode == jcws_pkg::SCAN_BLOCK_LT) begin
                ats = 1'b1;
              end
              mode = jcws_pkg::SCAN_NORMAL;
            end else begin
              cnt = 3'd1;
              cls = jcws_pkg::CLS_BODY;
            end
          end
          default: begin
            // line and html comment bodies run to the line end
            cnt = 3'd1;
            if (jcws_pkg::is_lt(u)) begin
              cls  = jcws_pkg::CLS_LINE_TERM;
              mode = jcws_pkg::SCAN_NORMAL;
              ats  = 1'b1;
            end else begin
              cls  = jcws_pkg::CLS_BODY;
              kind = jcws_pkg::comment_kind_e'(mode);
            end
          end
        endcase
      end
      for (int j = 0; j < BD; j++) begin
        if ((3'(j) >= pos) && (3'(j) < pos + cnt)) begin
          cls_w[j]  = cls;
          kind_w[j] = kind;
        end
      end
      pos = pos + cnt;
    end
    mode_w = mode;
    ats_w  = ats;
    pos_w  = pos;
  end

  always_comb begin : build_batch
    for (int j = 0; j < BD; j++) begin
      if (in_token_i && (3'(j) == pos_w)) begin
        batch_o.units[j]   = code_unit_i;
        batch_o.classes[j] = jcws_pkg::CLS_TOKEN;
        batch_o.kinds[j]   = jcws_pkg::KIND_NONE;
      end else begin
        batch_o.units[j]   = ubuf[j];
        batch_o.classes[j] = cls_w[j];
        batch_o.kinds[j]   = kind_w[j];
      end
    end
    batch_o.count  = pos_w + {2'b00, in_token_i};
    batch_o.unterm = end_of_source_i &&
                     ((mode_w == jcws_pkg::SCAN_BLOCK) || (mode_w == jcws_pkg::SCAN_BLOCK_LT));
    batch_o.eos    = end_of_source_i;
    for (int i = 0; i < LD; i++) begin
      held_d[i] = ubuf[pos_w[1:0] + 2'(i)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      module_mode_q <= 1'b0;
    end else if (cfg_wr_en_i) begin
      module_mode_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q       <= jcws_pkg::SCAN_NORMAL;
      ats_q        <= 1'b1;
      held_count_q <= '0;
    end else if (in_fire_i) begin
      if (end_of_source_i) begin
        scan_q       <= jcws_pkg::SCAN_NORMAL;
        ats_q        <= 1'b1;
        held_count_q <= '0;
      end else begin
        scan_q       <= mode_w;
        ats_q        <= in_token_i ? jcws_pkg::is_lt(code_unit_i) : ats_w;
        held_count_q <= 2'(n_w - pos_w);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      held_q <= held_d;
    end
  end

  // only normal mode waits on more than one unit
  `JCWS_ASSERT(a_held_in_comment, (scan_q == jcws_pkg::SCAN_NORMAL) || (held_count_q <= 2'd1),
               "more than one unit held inside a comment")
  `JCWS_ASSERT_NEXT(a_eos_clears, in_fire_i && end_of_source_i,
                    (held_count_q == 2'd0) && (scan_q == jcws_pkg::SCAN_NORMAL) && ats_q,
                    "scan state not cleared after end of source")

endmodule
`default_nettype wire

FILE: rtl/jcws_out_stage.sv
// Result buffer: holds one word's results and hands them out one per beat.
`timescale 1ns / 1ps
`default_nettype none
`include "js_comment_whitespace_skipper_macros.svh"
module jcws_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire jcws_pkg::batch_t  batch_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic                   in_ready_o,
  output jcws_pkg::word_t        word_o
);

  jcws_pkg::batch_t             batch_q;
  logic [jcws_pkg::CNT_W-1:0]   cnt_q;
  logic [1:0]                   rd_q;
  logic                         out_fire;
  logic                         last;

  assign out_valid_o = (cnt_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign last        = (cnt_q == jcws_pkg::CNT_W'(1));
  assign in_ready_o  = (cnt_q == '0) || (last && out_ready_i);

  always_comb begin
    word_o.unit   = batch_q.units[rd_q];
    word_o.cls    = batch_q.classes[rd_q];
    word_o.kind   = batch_q.kinds[rd_q];
    word_o.last   = last;
    word_o.unterm = batch_q.unterm && last;
    word_o.eos    = batch_q.eos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      cnt_q <= batch_i.count;
      rd_q  <= '0;
    end else if (out_fire) begin
      cnt_q <= cnt_q - jcws_pkg::CNT_W'(1);
      rd_q  <= rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      batch_q <= batch_i;
    end
  end

  `JCWS_ASSERT(a_cnt_max, cnt_q <= jcws_pkg::CNT_W'(jcws_pkg::BUF_DEPTH),
               "result count exceeds buffer depth")
  `JCWS_ASSERT_NEXT(a_rd_step, out_fire && !load_i, rd_q == ($past(rd_q) + 2'd1),
                    "read index did not advance after a taken word")

endmodule
`default_nettype wire

FILE: rtl/jcws_position.sv
// Line and column tracker, advanced by each result word as it leaves.
`timescale 1ns / 1ps
`default_nettype none
`include "js_comment_whitespace_skipper_macros.svh"
module jcws_position (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fire_i,
  input  wire jcws_pkg::word_t             word_i,
  output logic [jcws_pkg::POS_W-1:0]       line_o,
  output logic [jcws_pkg::POS_W-1:0]       column_o
);

  localparam int unsigned PW = jcws_pkg::POS_W;

  logic [PW-1:0] line_q;
  logic [PW-1:0] col_q;
  logic          crp_q;
  logic          pre_brk;
  logic          post_brk;
  logic [PW-1:0] line_d;
  logic [PW-1:0] col_d;

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    return (v == jcws_pkg::POS_MAX) ? v : v + PW'(1);
  endfunction

  // a pending CR not followed by LF breaks the line before this unit
  assign pre_brk  = crp_q && (word_i.unit != jcws_pkg::CH_LF);
  assign line_o   = pre_brk ? sat_inc(line_q) : line_q;
  assign column_o = pre_brk ? '0 : col_q;
  // CR defers its break to see whether LF follows
  assign post_brk = jcws_pkg::is_lt(word_i.unit) && (word_i.unit != jcws_pkg::CH_CR);
  assign line_d   = post_brk ? sat_inc(line_o) : line_o;
  assign col_d    = post_brk ? '0 : sat_inc(column_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= PW'(1);
      col_q  <= '0;
      crp_q  <= 1'b0;
    end else if (fire_i) begin
      if (word_i.last && word_i.eos) begin
        line_q <= PW'(1);
        col_q  <= '0;
        crp_q  <= 1'b0;
      end else begin
        line_q <= line_d;
        col_q  <= col_d;
        crp_q  <= (word_i.unit == jcws_pkg::CH_CR);
      end
    end
  end

  `JCWS_ASSERT(a_line_nonzero, line_q != '0, "line number is zero")
  `JCWS_ASSERT(a_cr_column, !crp_q || (col_q != '0), "pending CR with column zero")

endmodule
`default_nettype wire

FILE: rtl/js_comment_whitespace_skipper.sv
// Top level: classifies UTF-16 code units as JavaScript trivia with line and column.
// A word's results start in the cycle after it is accepted; held lookahead
//   units come out with the word that settles them.
// Throughput: one word per cycle; input waits until a word's 0 to 4 results are all taken.
// Reset (rst_ni low, asynchronous): scan state, lookahead, position and result buffer
//   clear, module_mode returns to 0. End of source clears scan state, lookahead and position.
`timescale 1ns / 1ps
`default_nettype none
module js_comment_whitespace_skipper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic        cfg_wr_data_i,    // module_mode
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,     // [15:0] code_unit
  input  wire logic [0:0]  s_axis_tuser,     // [0] in_token
  input  wire logic        s_axis_tlast,     // end_of_source
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,     // [15:0] out_unit, [39:16] line_number,
                                             // [63:40] column
  output logic [6:0]       m_axis_tuser,     // [2:0] unit_class, [5:3] comment_kind,
                                             // [6] unterminated
  output logic             m_axis_tlast      // last_of_run
);

  logic                           in_fire;
  logic                           out_fire;
  jcws_pkg::batch_t               batch;
  jcws_pkg::word_t                word;
  logic [jcws_pkg::POS_W-1:0]     line_num;
  logic [jcws_pkg::POS_W-1:0]     col_num;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  jcws_classifier u_classifier (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .in_fire_i       (in_fire),
    .code_unit_i     (s_axis_tdata),
    .in_token_i      (s_axis_tuser[0]),
    .end_of_source_i (s_axis_tlast),
    .batch_o         (batch)
  );

  jcws_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .batch_i     (batch),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .word_o      (word)
  );

  jcws_position u_position (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (out_fire),
    .word_i   (word),
    .line_o   (line_num),
    .column_o (col_num)
  );

  assign m_axis_tdata = {col_num, line_num, word.unit};
  assign m_axis_tuser = {word.unterm, word.kind, word.cls};
  assign m_axis_tlast = word.last;

endmodule
`default_nettype wire

FILE: tb/js_comment_whitespace_skipper_tb.sv
// Testbench for the JavaScript comment and whitespace skipper: directed and random sources.
`timescale 1ns / 1ps
module js_comment_whitespace_skipper_tb;
  import jcws_pkg::*;

  localparam logic [15:0] CH_LS   = 16'h2028;
  localparam logic [15:0] CH_PS   = 16'h2029;
  localparam int RANDOM_ITEMS     = 330;
  localparam int SETTLE_CYCLES    = 6;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TIMEOUT_NS       = 2_000_000;

  typedef struct {
    logic [15:0]      unit;
    unit_class_e      cls;
    comment_kind_e    kind;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] col;
    logic             unterm;
    logic             last;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_wr_en_i;
  logic        cfg_wr_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [6:0]  m_axis_tuser;
  logic        m_axis_tlast;

  js_comment_whitespace_skipper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // trivia scanner state
  logic             html_off;
  scan_mode_e       scan_st;
  logic [15:0]      held_q [LOOKAHEAD_DEPTH];
  int               held_n;
  logic             line_start;
  logic             cr_wait;
  logic [POS_W-1:0] line_cnt;
  logic [POS_W-1:0] col_cnt;
  logic [15:0]      scan_buf [BUF_DEPTH];

  result_t     word_results[$];
  result_t     pending_words[$];
  logic [15:0] src_units[$];
  logic        src_toks[$];

  int mismatch_cnt;
  int words_checked;
  int words_sent;
  int random_items;
  int sources_sent;
  int burst_left;
  int long_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic is_term(input logic [15:0] u);
    return u == CH_LF || u == CH_CR || u == CH_LS || u == CH_PS;
  endfunction

  function automatic logic is_space(input logic [15:0] u);
    case (u)
      16'h0009, 16'h000B, 16'h000C, 16'h0020, 16'h00A0, 16'hFEFF,
      16'h1680, 16'h202F, 16'h205F, 16'h3000: return 1'b1;
      default: return u >= 16'h2000 && u <= 16'h200A;
    endcase
  endfunction

  function automatic void clear_scan();
    scan_st    = SCAN_NORMAL;
    held_n     = 0;
    line_start = 1'b1;
    cr_wait    = 1'b0;
    line_cnt   = POS_W'(1);
    col_cnt    = '0;
  endfunction

  function automatic void next_line();
    if (line_cnt != POS_MAX) line_cnt++;
    col_cnt = 0;
  endfunction

  function automatic void put_unit(input logic [15:0] u, input unit_class_e c,
                                   input comment_kind_e k);
    result_t r;
    if (cr_wait && u != CH_LF) begin
      cr_wait = 1'b0;
      next_line();
    end
    r.unit   = u;
    r.cls    = c;
    r.kind   = k;
    r.line   = line_cnt;
    r.col    = col_cnt;
    r.unterm = 1'b0;
    r.last   = 1'b0;
    word_results.insert(word_results.size(), r);
    if (col_cnt != POS_MAX) col_cnt++;
    if (cr_wait) begin
      cr_wait = 1'b0;
      next_line();
    end else if (u == CH_CR) begin
      cr_wait = 1'b1;
    end else if (is_term(u)) begin
      next_line();
    end
  endfunction

  // 1 match, 0 mismatch, 2 not enough units yet
  function automatic int probe_seq(input int at, input int avail, input int plen,
                                   input logic [15:0] p0, input logic [15:0] p1,
                                   input logic [15:0] p2);
    logic [15:0] pat [3];
    pat[0] = p0;
    pat[1] = p1;
    pat[2] = p2;
    for (int i = 0; i < plen; i++) begin
      if (i + 1 >= avail) return 2;
      if (scan_buf[at + i + 1] != pat[i]) return 0;
    end
    return 1;
  endfunction

  // expected result words of one accepted input word
  function automatic void classify_word(input logic [15:0] cu, input logic tok,
                                        input logic eos);
    int            n;
    int            pos;
    int            rem;
    int            r_close;
    int            r_open;
    logic          can_wait;
    logic          hold;
    logic [15:0]   u;
    comment_kind_e k;
    result_t       r;
    word_results.delete();
    can_wait = !eos && !tok;
    n        = 0;
    pos      = 0;
    hold     = 1'b0;
    for (int i = 0; i < held_n; i++) begin
      scan_buf[n] = held_q[i];
      n++;
    end
    if (!tok) begin
      scan_buf[n] = cu;
      n++;
    end
    while (pos < n && !hold) begin
      u   = scan_buf[pos];
      rem = n - pos;
      if (scan_st == SCAN_NORMAL) begin
        if (is_space(u)) begin
          put_unit(u, CLS_WS, KIND_NONE);
          pos++;
        end else if (is_term(u)) begin
          put_unit(u, CLS_LINE_TERM, KIND_NONE);
          line_start = 1'b1;
          pos++;
        end else if (u == CH_SLASH && rem < 2 && can_wait) begin
          hold = 1'b1;
        end else if (u == CH_SLASH && rem >= 2 &&
                     (scan_buf[pos+1] == CH_SLASH || scan_buf[pos+1] == CH_STAR)) begin
          k = (scan_buf[pos+1] == CH_SLASH) ? KIND_LINE : KIND_BLOCK;
          put_unit(u, CLS_DELIM, k);
          put_unit(scan_buf[pos+1], CLS_DELIM, k);
          scan_st = (k == KIND_LINE) ? SCAN_LINE : SCAN_BLOCK;
          pos += 2;
        end else begin
          r_close = (u == CH_DASH && line_start) ?
                    probe_seq(pos, rem, 2, CH_DASH, CH_GREATER, CH_GREATER) : 0;
          r_open  = (u == CH_LESS && !html_off) ?
                    probe_seq(pos, rem, 3, CH_BANG, CH_DASH, CH_DASH) : 0;
          if (r_close == 1 || (r_close == 2 && can_wait)) begin
            if (r_close == 2) begin
              hold = 1'b1;
            end else begin
              for (int i = 0; i < 3; i++) put_unit(scan_buf[pos+i], CLS_DELIM, KIND_HTML_CLOSE);
              scan_st = SCAN_HTML_CLOSE;
              pos += 3;
            end
          end else if (r_open == 1 || (r_open == 2 && can_wait)) begin
            if (r_open == 2) begin
              hold = 1'b1;
            end else begin
              for (int i = 0; i < 4; i++) put_unit(scan_buf[pos+i], CLS_DELIM, KIND_HTML_OPEN);
              scan_st = SCAN_HTML_OPEN;
              pos += 4;
            end
          end else begin
            put_unit(u, CLS_CODE, KIND_NONE);
            line_start = 1'b0;
            pos++;
          end
        end
      end else if (scan_st == SCAN_BLOCK || scan_st == SCAN_BLOCK_LT) begin
        if (is_term(u)) begin
          put_unit(u, CLS_LINE_TERM, KIND_BLOCK);
          scan_st = SCAN_BLOCK_LT;
          pos++;
        end else if (u == CH_STAR && rem < 2 && can_wait) begin
          hold = 1'b1;
        end else if (u == CH_STAR && rem >= 2 && scan_buf[pos+1] == CH_SLASH) begin
          put_unit(u, CLS_DELIM, KIND_BLOCK);
          put_unit(scan_buf[pos+1], CLS_DELIM, KIND_BLOCK);
          if (scan_st == SCAN_BLOCK_LT) line_start = 1'b1;
          scan_st = SCAN_NORMAL;
          pos += 2;
        end else begin
          put_unit(u, CLS_BODY, KIND_BLOCK);
          pos++;
        end
      end else begin
        if (is_term(u)) begin
          put_unit(u, CLS_LINE_TERM, KIND_NONE);
          scan_st    = SCAN_NORMAL;
          line_start = 1'b1;
        end else begin
          case (scan_st)
            SCAN_LINE:      k = KIND_LINE;
            SCAN_HTML_OPEN: k = KIND_HTML_OPEN;
            default:        k = KIND_HTML_CLOSE;
          endcase
          put_unit(u, CLS_BODY, k);
        end
        pos++;
      end
    end
    held_n = n - pos;
    if (held_n > LOOKAHEAD_DEPTH) held_n = LOOKAHEAD_DEPTH;
    for (int i = 0; i < held_n; i++) held_q[i] = scan_buf[pos+i];
    if (tok) begin
      put_unit(cu, CLS_TOKEN, KIND_NONE);
      line_start = is_term(cu);
    end
    for (int i = 0; i < word_results.size(); i++) begin
      r = word_results[i];
      if (i == word_results.size() - 1) begin
        r.last   = 1'b1;
        r.unterm = eos && (scan_st == SCAN_BLOCK || scan_st == SCAN_BLOCK_LT);
      end
      pending_words.insert(pending_words.size(), r);
    end
    if (eos) clear_scan();
  endfunction

  function automatic void check_field(input string name, input logic [POS_W-1:0] want,
                                      input logic [POS_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word, unit %h", m_axis_tdata[15:0]);
        mismatch_cnt++;
      end else begin
        want = pending_words.pop_front();
        check_field("out_unit", POS_W'(want.unit), POS_W'(m_axis_tdata[15:0]));
        check_field("unit_class", POS_W'(want.cls), POS_W'(m_axis_tuser[2:0]));
        check_field("comment_kind", POS_W'(want.kind), POS_W'(m_axis_tuser[5:3]));
        check_field("line_number", want.line, m_axis_tdata[39:16]);
        check_field("column", want.col, m_axis_tdata[63:40]);
        check_field("unterminated", POS_W'(want.unterm), POS_W'(m_axis_tuser[6]));
        check_field("last_of_run", POS_W'(want.last), POS_W'(m_axis_tlast));
        words_checked++;
      end
    end
  end

  initial begin : sink_pattern
    int hold_left;
    int span_left;
    int style;
    hold_left = 0;
    span_left = 0;
    style     = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req > 0) begin
        hold_left     = long_hold_req;
        long_hold_req = 0;
      end
      if (span_left == 0) begin
        style     = $urandom_range(0, 3);
        span_left = $urandom_range(4, 60);
      end
      span_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
          2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_unit(input logic [15:0] cu, input logic tok, input logic eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cu;
    s_axis_tuser  <= tok;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    classify_word(cu, tok, eos);
    words_sent++;
  endtask

  task automatic send_text(input string s, input logic eos_last);
    for (int i = 0; i < s.len(); i++)
      send_unit({8'h00, s[i]}, 1'b0, eos_last && i == s.len() - 1);
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_module_mode(input logic v);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    html_off = v;
  endtask

  function automatic logic [15:0] pick_letter();
    return 16'h0061 + 16'($urandom_range(0, 25));
  endfunction

  function automatic logic [15:0] pick_ws();
    case ($urandom_range(0, 10))
      0:       return 16'h0009;
      1:       return 16'h000B;
      2:       return 16'h000C;
      3:       return 16'h0020;
      4:       return 16'h00A0;
      5:       return 16'hFEFF;
      6:       return 16'h1680;
      7:       return 16'h202F;
      8:       return 16'h205F;
      9:       return 16'h3000;
      default: return 16'h2000 + 16'($urandom_range(0, 10));
    endcase
  endfunction

  function automatic logic [15:0] pick_term();
    case ($urandom_range(0, 3))
      0:       return CH_LF;
      1:       return CH_CR;
      2:       return CH_LS;
      default: return CH_PS;
    endcase
  endfunction

  function automatic logic [15:0] pick_body();
    case ($urandom_range(0, 9))
      0, 1:    return pick_letter();
      2:       return 16'($urandom_range(0, 16'hFFFF));
      3:       return CH_STAR;
      4:       return CH_SLASH;
      5:       return CH_DASH;
      6:       return pick_ws();
      7:       return CH_LESS;
      8:       return CH_BANG;
      default: return ($urandom_range(0, 2) == 0) ? pick_term() : CH_GREATER;
    endcase
  endfunction

  function automatic logic [15:0] pick_tricky();
    case ($urandom_range(0, 6))
      0:       return CH_SLASH;
      1:       return CH_STAR;
      2:       return CH_DASH;
      3:       return CH_LESS;
      4:       return CH_LF;
      5:       return CH_CR;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic void push_unit(input logic [15:0] u, input logic tok);
    src_units.insert(src_units.size(), u);
    src_toks.insert(src_toks.size(), tok);
  endfunction

  // mostly well-formed trivia with random content, plus fragments and noise
  function automatic void build_source(input int frags);
    src_units.delete();
    src_toks.delete();
    for (int f = 0; f < frags; f++) begin
      case ($urandom_range(0, 12))
        0: push_unit(pick_letter(), 1'b0);
        1: push_unit(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3) == 0);
        2: push_unit(pick_ws(), 1'b0);
        3: begin
          if ($urandom_range(0, 1) == 1) begin
            push_unit(CH_CR, 1'b0);
            push_unit(CH_LF, 1'b0);
          end else begin
            push_unit(pick_term(), 1'b0);
          end
        end
        4: begin
          push_unit(CH_SLASH, 1'b0);
          push_unit(CH_SLASH, 1'b0);
          repeat ($urandom_range(0, 4)) push_unit(pick_body(), 1'b0);
          push_unit(pick_term(), 1'b0);
        end
        5: begin
          push_unit(CH_SLASH, 1'b0);
          push_unit(CH_STAR, 1'b0);
          repeat ($urandom_range(0, 5)) push_unit(pick_body(), 1'b0);
          if ($urandom_range(0, 1) == 1) push_unit(pick_term(), 1'b0);
          if ($urandom_range(0, 5) != 0) begin
            push_unit(CH_STAR, 1'b0);
            push_unit(CH_SLASH, 1'b0);
          end
        end
        6: begin
          push_unit(CH_LESS, 1'b0);
          push_unit(CH_BANG, 1'b0);
          push_unit(CH_DASH, 1'b0);
          push_unit(CH_DASH, 1'b0);
          repeat ($urandom_range(0, 3)) push_unit(pick_body(), 1'b0);
          push_unit(pick_term(), 1'b0);
        end
        7: begin
          push_unit(pick_term(), 1'b0);
          push_unit(CH_DASH, 1'b0);
          push_unit(CH_DASH, 1'b0);
          push_unit(CH_GREATER, 1'b0);
          repeat ($urandom_range(0, 3)) push_unit(pick_body(), 1'b0);
        end
        8: begin
          case ($urandom_range(0, 5))
            0: push_unit(CH_SLASH, 1'b0);
            1: push_unit(CH_DASH, 1'b0);
            2: begin
              push_unit(CH_DASH, 1'b0);
              push_unit(CH_DASH, 1'b0);
            end
            3: push_unit(CH_LESS, 1'b0);
            4: begin
              push_unit(CH_LESS, 1'b0);
              push_unit(CH_BANG, 1'b0);
            end
            default: begin
              push_unit(CH_LESS, 1'b0);
              push_unit(CH_BANG, 1'b0);
              push_unit(CH_DASH, 1'b0);
            end
          endcase
        end
        9: repeat ($urandom_range(1, 3)) push_unit(pick_tricky(), 1'b1);
        10: begin
          push_unit(CH_STAR, 1'b0);
          push_unit(CH_SLASH, 1'b0);
        end
        11: begin
          push_unit(CH_DASH, 1'b0);
          push_unit(CH_DASH, 1'b0);
          push_unit(CH_GREATER, 1'b0);
        end
        default: repeat ($urandom_range(1, 4))
          push_unit(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 1) == 1);
      endcase
    end
  endfunction

  task automatic send_source();
    for (int i = 0; i < src_units.size(); i++)
      send_unit(src_units[i], src_toks[i], i == src_units.size() - 1);
    sources_sent++;
  endtask

  // CR LF as one break, lone CR, separators, extreme code units
  task automatic test_terminators();
    send_unit(CH_CR, 1'b0, 1'b0);
    send_unit(CH_LF, 1'b0, 1'b0);
    send_unit(CH_CR, 1'b0, 1'b0);
    send_unit(16'hFFFF, 1'b0, 1'b0);
    send_unit(CH_LS, 1'b0, 1'b0);
    send_unit(16'hFEFF, 1'b0, 1'b0);
    send_unit(CH_PS, 1'b0, 1'b1);
  endtask

  task automatic test_html_comments();
    send_text("<!--", 1'b0);
    send_unit(CH_LF, 1'b0, 1'b0);
    send_text("-->", 1'b0);
    send_unit(CH_LF, 1'b0, 1'b0);
    send_text("//", 1'b0);
    send_unit(16'h0000, 1'b0, 1'b1);
  endtask

  // block holding a terminator, then one left open at end of source
  task automatic test_block_comments();
    send_text("/*", 1'b0);
    send_unit(CH_LS, 1'b0, 1'b0);
    send_text("*//*", 1'b0);
    send_unit(CH_STAR, 1'b0, 1'b1);
  endtask

  // openers cut short by a token unit and by end of source
  task automatic test_cut_short();
    send_unit(CH_SLASH, 1'b0, 1'b0);
    send_unit(CH_LF, 1'b1, 1'b0);
    send_unit(CH_DASH, 1'b0, 1'b0);
    send_unit(CH_DASH, 1'b0, 1'b1);
  endtask

  task automatic test_module_mode();
    wait_quiet();
    set_module_mode(1'b1);
    send_text("<!--", 1'b1);
    wait_quiet();
    set_module_mode(1'b0);
  endtask

  task automatic test_random_sources();
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        wait_quiet();
        set_module_mode(1'($urandom_range(0, 1)));
      end
      build_source($urandom_range(2, 12));
      random_items += src_units.size();
      send_source();
    end
  endtask

  // output held off long enough for the input side to stall
  task automatic test_backpressure();
    wait_quiet();
    long_hold_req = LONG_HOLD_CYCLES;
    build_source(14);
    send_source();
    wait_quiet();
  endtask

  initial begin
    int waited;
    mismatch_cnt  = 0;
    words_checked = 0;
    words_sent    = 0;
    random_items  = 0;
    sources_sent  = 0;
    burst_left    = 0;
    long_hold_req = 0;
    html_off      = 1'b0;
    clear_scan();
    rst_ni        <= 1'b0;
    cfg_wr_en_i   <= 1'b0;
    cfg_wr_data_i <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_terminators();
    test_html_comments();
    test_block_comments();
    test_cut_short();
    test_module_mode();
    test_random_sources();
    test_backpressure();

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_words.size() != 0 && waited < 50000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      $error("%0d expected result words never arrived", pending_words.size());
      mismatch_cnt++;
    end
    $display("Sent %0d code units in %0d random sources plus directed runs, both mode settings.",
             words_sent, sources_sent);
    $display("Compared %0d result words, including a long output stall.", words_checked);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
